### hw/rtl/rtph26x_pkg.sv
package rtph26x_pkg;

	localparam int unsigned BufferBytes = 1048576;
	localparam int CntW = 25;
	localparam int QDepth = 4;
	localparam int QPtrW = 2;

	localparam logic [2:0] M_SKIP      = 3'd0;
	localparam logic [2:0] M_COPY      = 3'd1;
	localparam logic [2:0] M_AGG_HI    = 3'd2;
	localparam logic [2:0] M_AGG_LO    = 3'd3;
	localparam logic [2:0] M_AGG_DATA  = 3'd4;
	localparam logic [2:0] M_FU_HDR    = 3'd5;
	localparam logic [2:0] M_H265_FU2  = 3'd6;
	localparam logic [2:0] M_H265_AGG2 = 3'd7;

	localparam logic [1:0] K_BYTE   = 2'd0;
	localparam logic [1:0] K_FRAME  = 2'd1;
	localparam logic [1:0] K_DROP   = 2'd2;
	localparam logic [1:0] K_STATUS = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_PT      = 2'd2;
	localparam logic [1:0] ST_NAL     = 2'd3;

	localparam logic [1:0] STREAM_RAW  = 2'd0;
	localparam logic [1:0] STREAM_H264 = 2'd1;
	localparam logic [1:0] STREAM_H265 = 2'd2;

	localparam logic REG_STREAM_TYPE  = 1'b0;
	localparam logic REG_PAYLOAD_TYPE = 1'b1;

	// Work for one input byte, expanded by the emitter
	typedef struct packed {
		logic        ev_frame;
		logic [20:0] ev_frame_len;
		logic [31:0] ev_frame_ts;
		logic        ev_drop;
		logic [20:0] ev_drop_len;
		logic [31:0] ts;
		logic [31:0] ssrc;
		logic        start_code;
		logic [1:0]  n_bytes;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic        ev_status;
		logic [1:0]  status;
	} rtph26x_cmd_t;

endpackage

### hw/rtl/rtph26x_parse.sv
module rtph26x_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                stream_type,
	input  logic [6:0]                payload_type,
	input  logic                      in_fire,
	input  logic [7:0]                data_byte,
	input  logic [15:0]               packet_length,
	input  logic                      last_byte,
	output logic                      cmd_valid,
	output rtph26x_pkg::rtph26x_cmd_t cmd
);

	logic [15:0] byte_index_q;
	logic [17:0] header_length_q;
	logic        packet_ok_q;
	logic [2:0]  nal_mode_q;
	logic [7:0]  saved_nal_q;
	logic [15:0] agg_left_q;
	logic [7:0]  len_high_q;
	logic [31:0] prev_ts_q;
	logic [31:0] in_ts_q;
	logic [31:0] in_ssrc_q;
	logic [20:0] frame_count_q;
	logic [1:0]  status_q;
	logic        in_payload_q;
	logic [7:0]  second_q;
	logic        fu_h265_q;

	logic [15:0] n_byte_index;
	logic [17:0] n_header_length;
	logic        n_packet_ok;
	logic [2:0]  n_nal_mode;
	logic [7:0]  n_saved_nal;
	logic [15:0] n_agg_left;
	logic [7:0]  n_len_high;
	logic [31:0] n_prev_ts;
	logic [31:0] n_in_ts;
	logic [31:0] n_in_ssrc;
	logic [20:0] n_frame_count;
	logic [1:0]  n_status;
	logic        n_in_payload;
	logic [7:0]  n_second;
	logic        n_fu_h265;

	rtph26x_pkg::rtph26x_cmd_t c;

	logic [15:0] i;
	logic [15:0] rem;
	logic [15:0] after;
	logic [20:0] fc;
	logic [5:0]  nal;
	logic [15:0] alen;
	logic        first;
	logic [17:0] need;
	logic [17:0] hl_tmp;

	function automatic logic fits(input logic [20:0] count, input logic [17:0] n);
		logic [rtph26x_pkg::CntW-1:0] sum;
		sum = rtph26x_pkg::CntW'(count) + rtph26x_pkg::CntW'(n);
		return sum <= rtph26x_pkg::CntW'(rtph26x_pkg::BufferBytes);
	endfunction

	always_comb begin
		n_byte_index    = byte_index_q;
		n_header_length = header_length_q;
		n_packet_ok     = packet_ok_q;
		n_nal_mode      = nal_mode_q;
		n_saved_nal     = saved_nal_q;
		n_agg_left      = agg_left_q;
		n_len_high      = len_high_q;
		n_prev_ts       = prev_ts_q;
		n_in_ts         = in_ts_q;
		n_in_ssrc       = in_ssrc_q;
		n_status        = status_q;
		n_in_payload    = in_payload_q;
		n_second        = second_q;
		n_fu_h265       = fu_h265_q;
		c               = '0;
		i               = byte_index_q;
		rem             = packet_length - i;
		after           = packet_length - i - 16'd1;
		fc              = frame_count_q;
		nal             = '0;
		alen            = {len_high_q, data_byte};
		first           = data_byte[7];
		need            = '0;
		hl_tmp          = '0;
		c.ts            = in_ts_q;
		c.ssrc          = in_ssrc_q;

		if (packet_ok_q && i < packet_length) begin
			if (i == 16'd0) begin
				if (packet_length <= 16'd12 || data_byte[7:6] != 2'd2) begin
					n_packet_ok = 1'b0;
					n_status    = rtph26x_pkg::ST_INVALID;
				end else if (data_byte[4]) begin
					n_header_length = 18'd16;
				end
			end else if (i == 16'd1) begin
				if (data_byte[6:0] != payload_type) begin
					n_packet_ok = 1'b0;
					n_status    = rtph26x_pkg::ST_PT;
				end
			end else if (i >= 16'd4 && i < 16'd8) begin
				n_in_ts = {in_ts_q[23:0], data_byte};
			end else if (i >= 16'd8 && i < 16'd12) begin
				n_in_ssrc = {in_ssrc_q[23:0], data_byte};
			end else if (i < 16'd12) begin
				n_nal_mode = nal_mode_q;
			end else if (header_length_q >= 18'd16 && i == 16'd14) begin
				n_header_length = 18'd16 + {data_byte, 10'd0};
			end else if (header_length_q >= 18'd16 && i == 16'd15) begin
				hl_tmp          = {8'd0, data_byte, 2'd0};
				n_header_length = header_length_q + hl_tmp;
			end else if (18'(i) < header_length_q) begin
				n_nal_mode = nal_mode_q;
			end else if (18'(i) == header_length_q && !in_payload_q) begin
				n_in_payload = 1'b1;
				n_fu_h265    = 1'b0;
				if (in_ts_q != prev_ts_q && frame_count_q != 21'd0) begin
					c.ev_frame     = 1'b1;
					c.ev_frame_len = frame_count_q;
					c.ev_frame_ts  = prev_ts_q;
					fc             = '0;
				end
				n_prev_ts   = in_ts_q;
				n_saved_nal = data_byte;
				n_nal_mode  = rtph26x_pkg::M_SKIP;
				if (stream_type == rtph26x_pkg::STREAM_H264 ||
				    stream_type == rtph26x_pkg::STREAM_H265) begin
					if (stream_type == rtph26x_pkg::STREAM_H264)
						nal = {1'b0, data_byte[4:0]};
					else
						nal = data_byte[6:1];
					if ((stream_type == rtph26x_pkg::STREAM_H264 && nal < 6'd24) ||
					    (stream_type == rtph26x_pkg::STREAM_H265 && nal < 6'd48)) begin
						if (fits(fc, 18'(rem) + 18'd4)) begin
							c.start_code = 1'b1;
							c.n_bytes    = 2'd1;
							c.byte0      = data_byte;
							n_nal_mode   = rtph26x_pkg::M_COPY;
						end else begin
							c.ev_drop     = 1'b1;
							c.ev_drop_len = fc;
						end
					end else if (stream_type == rtph26x_pkg::STREAM_H264 && nal == 6'd24) begin
						n_nal_mode = rtph26x_pkg::M_AGG_HI;
					end else if (stream_type == rtph26x_pkg::STREAM_H264 && nal == 6'd28) begin
						n_nal_mode = rtph26x_pkg::M_FU_HDR;
					end else if (nal == 6'd48) begin
						n_nal_mode = rtph26x_pkg::M_H265_AGG2;
					end else if (nal == 6'd49) begin
						n_nal_mode = rtph26x_pkg::M_H265_FU2;
					end else begin
						n_status = rtph26x_pkg::ST_NAL;
					end
				end else begin
					if (fits(fc, 18'(rem))) begin
						c.n_bytes  = 2'd1;
						c.byte0    = data_byte;
						n_nal_mode = rtph26x_pkg::M_COPY;
					end else begin
						c.ev_drop     = 1'b1;
						c.ev_drop_len = fc;
						n_status      = rtph26x_pkg::ST_INVALID;
					end
				end
			end else if (in_payload_q) begin
				case (nal_mode_q)
					rtph26x_pkg::M_COPY: begin
						c.n_bytes = 2'd1;
						c.byte0   = data_byte;
					end
					rtph26x_pkg::M_AGG_HI: begin
						if (rem > 16'd2) begin
							n_len_high = data_byte;
							n_nal_mode = rtph26x_pkg::M_AGG_LO;
						end else begin
							n_nal_mode = rtph26x_pkg::M_SKIP;
						end
					end
					rtph26x_pkg::M_AGG_LO: begin
						if (alen != 16'd0 && alen <= after && fits(fc, 18'(alen) + 18'd4)) begin
							c.start_code = 1'b1;
							n_agg_left   = alen;
							n_nal_mode   = rtph26x_pkg::M_AGG_DATA;
						end else begin
							n_nal_mode = rtph26x_pkg::M_SKIP;
						end
					end
					rtph26x_pkg::M_AGG_DATA: begin
						c.n_bytes  = 2'd1;
						c.byte0    = data_byte;
						n_agg_left = agg_left_q - 16'd1;
						if (n_agg_left == 16'd0)
							n_nal_mode = rtph26x_pkg::M_AGG_HI;
					end
					rtph26x_pkg::M_FU_HDR: begin
						if (first)
							need = 18'(after) + (fu_h265_q ? 18'd6 : 18'd5);
						else
							need = 18'(after);
						if (fits(fc, need)) begin
							if (first) begin
								c.start_code = 1'b1;
								if (fu_h265_q) begin
									c.n_bytes = 2'd2;
									c.byte0   = (saved_nal_q & 8'h81) |
									            ({data_byte[6:0], 1'b0} & 8'h7E);
									c.byte1   = second_q;
								end else begin
									c.n_bytes = 2'd1;
									c.byte0   = (saved_nal_q & 8'hE0) | (data_byte & 8'h1F);
								end
							end
							n_nal_mode = rtph26x_pkg::M_COPY;
						end else begin
							c.ev_drop     = 1'b1;
							c.ev_drop_len = fc;
							n_nal_mode    = rtph26x_pkg::M_SKIP;
						end
					end
					rtph26x_pkg::M_H265_FU2: begin
						n_second   = data_byte;
						n_fu_h265  = 1'b1;
						n_nal_mode = rtph26x_pkg::M_FU_HDR;
					end
					rtph26x_pkg::M_H265_AGG2: begin
						n_nal_mode = rtph26x_pkg::M_AGG_HI;
					end
					default: begin
						n_nal_mode = nal_mode_q;
					end
				endcase
			end
		end

		if (c.ev_drop)
			n_frame_count = '0;
		else
			n_frame_count = fc + (c.start_code ? 21'd4 : 21'd0) + 21'(c.n_bytes);

		if (last_byte) begin
			c.ev_status = 1'b1;
			if (n_packet_ok && !n_in_payload)
				c.status = rtph26x_pkg::ST_INVALID;
			else
				c.status = n_status;
			n_byte_index    = '0;
			n_header_length = 18'd12;
			n_packet_ok     = 1'b1;
			n_nal_mode      = rtph26x_pkg::M_SKIP;
			n_status        = rtph26x_pkg::ST_OK;
			n_in_payload    = 1'b0;
			n_fu_h265       = 1'b0;
		end else if (byte_index_q != 16'hFFFF) begin
			n_byte_index = byte_index_q + 16'd1;
		end
	end

	assign cmd_valid = in_fire && (c.ev_frame || c.ev_drop || c.start_code ||
	                               c.n_bytes != 2'd0 || c.ev_status);
	assign cmd = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= '0;
			header_length_q <= 18'd12;
			packet_ok_q     <= 1'b1;
			nal_mode_q      <= rtph26x_pkg::M_SKIP;
			saved_nal_q     <= '0;
			agg_left_q      <= '0;
			len_high_q      <= '0;
			prev_ts_q       <= '0;
			in_ts_q         <= '0;
			in_ssrc_q       <= '0;
			frame_count_q   <= '0;
			status_q        <= rtph26x_pkg::ST_OK;
			in_payload_q    <= 1'b0;
			second_q        <= '0;
			fu_h265_q       <= 1'b0;
		end else if (in_fire) begin
			byte_index_q    <= n_byte_index;
			header_length_q <= n_header_length;
			packet_ok_q     <= n_packet_ok;
			nal_mode_q      <= n_nal_mode;
			saved_nal_q     <= n_saved_nal;
			agg_left_q      <= n_agg_left;
			len_high_q      <= n_len_high;
			prev_ts_q       <= n_prev_ts;
			in_ts_q         <= n_in_ts;
			in_ssrc_q       <= n_in_ssrc;
			frame_count_q   <= n_frame_count;
			status_q        <= n_status;
			in_payload_q    <= n_in_payload;
			second_q        <= n_second;
			fu_h265_q       <= n_fu_h265;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		frame_count_q <= 21'(rtph26x_pkg::BufferBytes))
		else $error("frame count above buffer size");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && c.ev_drop |-> !c.start_code && c.n_bytes == 2'd0)
		else $error("drop with stream bytes");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_byte |=> byte_index_q == 16'd0 && packet_ok_q)
		else $error("packet state not cleared");

endmodule

### hw/rtl/rtph26x_queue.sv
module rtph26x_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rtph26x_pkg::rtph26x_cmd_t push_cmd,
	output logic                      full,
	output logic                      almost_full,
	input  logic                      pop,
	output logic                      not_empty,
	output rtph26x_pkg::rtph26x_cmd_t head
);

	rtph26x_pkg::rtph26x_cmd_t mem_q [rtph26x_pkg::QDepth];
	logic [rtph26x_pkg::QPtrW-1:0] wr_q, rd_q;
	logic [rtph26x_pkg::QPtrW:0]   cnt_q;

	assign full        = cnt_q == (rtph26x_pkg::QPtrW+1)'(rtph26x_pkg::QDepth);
	assign almost_full = cnt_q >= (rtph26x_pkg::QPtrW+1)'(rtph26x_pkg::QDepth - 1);
	assign not_empty   = cnt_q != '0;
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (rtph26x_pkg::QPtrW+1)'(rtph26x_pkg::QDepth))
		else $error("queue count out of range");

endmodule

### hw/rtl/rtph26x_emit.sv
module rtph26x_emit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  rtph26x_pkg::rtph26x_cmd_t cmd,
	output logic                      cmd_pop,
	output logic                      valid,
	input  logic                      stall,
	output logic [1:0]                kind,
	output logic [7:0]                out_byte,
	output logic [20:0]               frame_length,
	output logic [31:0]               frame_timestamp,
	output logic [31:0]               frame_ssrc,
	output logic [1:0]                packet_status,
	output logic                      last_of_run
);

	// Result slots of one command, in order:
	// 0 frame, 1 drop, 2..5 start code, 6..7 bytes, 8 status
	logic [8:0] pend;
	logic [8:0] done_q;
	logic [8:0] rest;
	logic [3:0] sel;
	logic       found;
	logic       more;
	logic       load;

	logic [1:0]  kind_n;
	logic [7:0]  byte_n;
	logic [20:0] flen_n;
	logic [31:0] ts_n;
	logic [31:0] ssrc_n;
	logic [1:0]  st_n;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [20:0] flen_q;
	logic [31:0] ts_q;
	logic [31:0] ssrc_q;
	logic [1:0]  st_q;
	logic        last_q;

	always_comb begin
		pend = {cmd.ev_status, cmd.n_bytes == 2'd2, cmd.n_bytes != 2'd0,
		        {4{cmd.start_code}}, cmd.ev_drop, cmd.ev_frame};
		if (!cmd_valid)
			pend = '0;
		pend  = pend & ~done_q;
		sel   = '0;
		found = 1'b0;
		for (int k = 8; k >= 0; k--) begin
			if (pend[k]) begin
				sel   = 4'(k);
				found = 1'b1;
			end
		end
		rest = pend;
		rest[sel] = 1'b0;
		more = rest != '0;
	end

	always_comb begin
		kind_n = rtph26x_pkg::K_BYTE;
		byte_n = '0;
		flen_n = '0;
		ts_n   = '0;
		ssrc_n = '0;
		st_n   = '0;
		case (sel)
			4'd0: begin
				kind_n = rtph26x_pkg::K_FRAME;
				flen_n = cmd.ev_frame_len;
				ts_n   = cmd.ev_frame_ts;
				ssrc_n = cmd.ssrc;
			end
			4'd1: begin
				kind_n = rtph26x_pkg::K_DROP;
				flen_n = cmd.ev_drop_len;
				ts_n   = cmd.ts;
				ssrc_n = cmd.ssrc;
			end
			4'd5: byte_n = 8'd1;
			4'd6: byte_n = cmd.byte0;
			4'd7: byte_n = cmd.byte1;
			4'd8: begin
				kind_n = rtph26x_pkg::K_STATUS;
				st_n   = cmd.status;
			end
			default: byte_n = 8'd0;
		endcase
	end

	assign load    = found && (!valid_q || !stall);
	assign cmd_pop = load && !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!stall)
				valid_q <= 1'b0;
			if (load)
				done_q <= more ? (done_q | (9'd1 << sel)) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_n;
			byte_q <= byte_n;
			flen_q <= flen_n;
			ts_q   <= ts_n;
			ssrc_q <= ssrc_n;
			st_q   <= st_n;
			last_q <= !more;
		end
	end

	assign valid           = valid_q;
	assign kind            = kind_q;
	assign out_byte        = byte_q;
	assign frame_length    = flen_q;
	assign frame_timestamp = ts_q;
	assign frame_ssrc      = ssrc_q;
	assign packet_status   = st_q;
	assign last_of_run     = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("pop without command");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && stall |=> valid_q && $stable(kind_q) && $stable(byte_q))
		else $error("result changed under stall");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |=> done_q == '0)
		else $error("slot mask not cleared");

endmodule

### hw/rtl/rtp_h26x_depacketizer.sv
// An accepted byte's command is queued; the emitter registers its results.
// Throughput: one byte per cycle when it causes at most one result and no
// out_stall or full queue holds it; a byte causing more results keeps the
// single-result emitter busy; the 4-entry command queue absorbs such bursts.
// Reset: arst_n clears all packet and frame state; registers return to
// stream_type 0 and payload_type 96.
module rtp_h26x_depacketizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [15:0] packet_length,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [20:0] frame_length,
	output logic [31:0] frame_timestamp,
	output logic [31:0] frame_ssrc,
	output logic [1:0]  packet_status,
	output logic        last_of_run
);

	logic [1:0] stream_type_q;
	logic [6:0] payload_type_q;
	logic       in_fire;
	logic       cmd_valid;
	logic       q_full, q_afull, q_ne, q_pop;
	rtph26x_pkg::rtph26x_cmd_t cmd, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_type_q  <= rtph26x_pkg::STREAM_RAW;
			payload_type_q <= 7'd96;
		end else if (cfg_valid) begin
			case (cfg_index)
				rtph26x_pkg::REG_STREAM_TYPE:  stream_type_q  <= cfg_data[1:0];
				rtph26x_pkg::REG_PAYLOAD_TYPE: payload_type_q <= cfg_data[6:0];
				default: stream_type_q <= stream_type_q;
			endcase
		end
	end

	// Hold input while the queue cannot take another command
	assign in_stall = q_full;
	assign in_fire  = in_valid && !in_stall;

	rtph26x_parse u_parse (
		.clk(clk), .arst_n(arst_n),
		.stream_type(stream_type_q), .payload_type(payload_type_q),
		.in_fire(in_fire), .data_byte(data_byte),
		.packet_length(packet_length), .last_byte(last_byte),
		.cmd_valid(cmd_valid), .cmd(cmd)
	);

	rtph26x_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(cmd_valid), .push_cmd(cmd),
		.full(q_full), .almost_full(q_afull),
		.pop(q_pop), .not_empty(q_ne), .head(head)
	);

	rtph26x_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_ne), .cmd(head), .cmd_pop(q_pop),
		.valid(out_valid), .stall(out_stall),
		.kind(kind), .out_byte(out_byte), .frame_length(frame_length),
		.frame_timestamp(frame_timestamp), .frame_ssrc(frame_ssrc),
		.packet_status(packet_status), .last_of_run(last_of_run)
	);

	assert property (@(posedge clk) disable iff (!arst_n) in_fire |-> !q_full)
		else $error("byte accepted into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> q_afull)
		else $error("queue level flags disagree");
	assert property (@(posedge clk) disable iff (!arst_n) cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule
